// File: rtl/pcc_pkg.sv
// Shared types, constants and series coefficient tables for the cosine curve evaluator.
package pcc_pkg;

  // Angle pi in unsigned Q2.30, rounded to nearest.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Full-scale weight in Q1.14.
  localparam logic [14:0] WEIGHT_ONE = 15'd16384;

  // Number of correction terms in the sine series (through x^17).
  localparam logic [3:0] TAYLOR_TERMS = 4'd8;

  // Item kinds on the input channel.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } pcc_kind_e;

  // Register decode on word address bit 2.
  typedef enum logic {
    REG_KNOT_COUNT  = 1'b0,
    REG_BASE_HEIGHT = 1'b1
  } pcc_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_XMUL,
    ST_X2MUL,
    ST_X2GET,
    ST_TMUL,
    ST_TRCP,
    ST_TCHK,
    ST_TUPD,
    ST_SQR,
    ST_SQGET,
    ST_YGET
  } pcc_state_e;

  // Status of the phase divider.
  typedef struct packed {
    logic busy;
    logic done;
  } pcc_div_stat_t;

  // Divisor (2k)(2k+1) of series term k.
  function automatic logic [8:0] taylor_div(input logic [3:0] k);
    case (k)
      4'd1:    return 9'd6;
      4'd2:    return 9'd20;
      4'd3:    return 9'd42;
      4'd4:    return 9'd72;
      4'd5:    return 9'd110;
      4'd6:    return 9'd156;
      4'd7:    return 9'd210;
      4'd8:    return 9'd272;
      default: return 9'd6;
    endcase
  endfunction

  // Shift that goes with the reciprocal of term k: 31 + ceil(log2(divisor)).
  function automatic logic [5:0] taylor_shift(input logic [3:0] k);
    case (k)
      4'd1:    return 6'd34;
      4'd2:    return 6'd36;
      4'd3:    return 6'd37;
      4'd4:    return 6'd38;
      4'd5:    return 6'd38;
      4'd6:    return 6'd39;
      4'd7:    return 6'd39;
      4'd8:    return 6'd40;
      default: return 6'd34;
    endcase
  endfunction

  // Truncated reciprocal floor(2^shift / divisor); the estimate is low by at most one.
  function automatic logic [31:0] taylor_recip(input logic [3:0] k);
    case (k)
      4'd1:    return 32'((64'd1 << 34) / 64'd6);
      4'd2:    return 32'((64'd1 << 36) / 64'd20);
      4'd3:    return 32'((64'd1 << 37) / 64'd42);
      4'd4:    return 32'((64'd1 << 38) / 64'd72);
      4'd5:    return 32'((64'd1 << 38) / 64'd110);
      4'd6:    return 32'((64'd1 << 39) / 64'd156);
      4'd7:    return 32'((64'd1 << 39) / 64'd210);
      4'd8:    return 32'((64'd1 << 40) / 64'd272);
      default: return 32'((64'd1 << 34) / 64'd6);
    endcase
  endfunction

endpackage

// File: rtl/pcc_ram.sv
// Generic single-port-write, registered-read RAM.
module pcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pcc_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
module pcc_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // One product per cycle, available on the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/pcc_div.sv
// Radix-2 restoring divider for the segment phase, one quotient bit per cycle.
module pcc_div
  import pcc_pkg::*;
#(
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [15:0]           dx_i,
  input  logic [15:0]           width_i,
  output logic [PHASE_BITS:0]   quo_o,
  output pcc_div_stat_t         stat_o
);

  localparam int CW = $clog2(PHASE_BITS + 2);

  logic [16:0]         rem_q;
  logic [16:0]         rem_d;
  logic [16:0]         rem_sh;
  logic [15:0]         width_q;
  logic [PHASE_BITS:0] quo_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;
  logic                first_q;
  logic                bit_ge;

  // The first step compares the offset itself (it never exceeds the width), later steps double.
  always_comb begin
    rem_sh = first_q ? rem_q : {rem_q[15:0], 1'b0};
    bit_ge = rem_sh >= {1'b0, width_q};
    rem_d  = bit_ge ? (rem_sh - {1'b0, width_q}) : rem_sh;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CW'(PHASE_BITS + 1);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= {1'b0, dx_i};
      width_q <= width_i;
      quo_q   <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[PHASE_BITS-1:0], bit_ge};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/piecewise_cosine_curve_eval.sv
// Piecewise cosine curve evaluator: knot table, segment scan and cosine-weighted blend.
//
//   Channel  Handshake                     Payload
//   in       in_valid_i / in_stall_o      kind_i, knot_index_i, knot_x_i, knot_y_i, query_x_i
//   out      out_valid_o / out_stall_i    height_o, in_segment_o
//   cfg      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A knot write goes into the knot table. An evaluate with fewer than two knots answers with
// the base height without a scan, a miss once every knot has been scanned, and a hit passes
// through a start state, the scan states (one knot read each), the phase divider (skipped for a
// zero-width segment) and the multiplier states for the angle, its square, the series and weight.
// Reset clears the configuration registers and the sequencer; the knot table is not cleared.
// A new item is taken only once the previous result has been accepted downstream.
module piecewise_cosine_curve_eval
  import pcc_pkg::*;
#(
  parameter int MAX_KNOTS  = 8,
  parameter int PHASE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [2:0]         knot_index_i,
  input  logic signed [15:0] knot_x_i,
  input  logic signed [15:0] knot_y_i,
  input  logic signed [15:0] query_x_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] height_o,
  output logic               in_segment_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int          IDX_W  = $clog2(MAX_KNOTS);
  localparam int          CNT_W  = $clog2(MAX_KNOTS + 1);
  localparam logic [63:0] SPAN64 = 64'd1 << PHASE_BITS;

  // Configuration registers.
  logic [3:0]         knot_count_q;
  logic signed [15:0] base_height_q;
  logic               cfg_wr;

  // Sequencer and control.
  pcc_state_e         state_q, state_d;
  logic               out_valid_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   last_q;
  logic [3:0]         k_q;
  logic               in_acc;
  logic               is_eval;
  logic [CNT_W-1:0]   n_eff;
  logic               enough_knots;

  // Knot RAM.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [15:0] rd_x;
  logic signed [15:0] rd_y;

  // Scan datapath.
  logic signed [15:0] q_q;
  logic signed [15:0] prev_x_q;
  logic signed [15:0] prev_y_q;
  logic signed [15:0] y0_q;
  logic               neg_q;
  logic [15:0]        mag_q;
  logic               hit;
  logic [16:0]        dx_full;
  logic [16:0]        w_full;
  logic signed [16:0] dy_full;
  logic [16:0]        dy_abs;

  // Divider.
  logic               div_start;
  logic [PHASE_BITS:0] div_quo;
  pcc_div_stat_t      div_stat;
  logic [PHASE_BITS:0] t_q;

  // Multiplier and weight datapath.
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic [31:0]        x_calc;
  logic [31:0]        x2_calc;
  logic [31:0]        v_calc;
  logic [31:0]        est_calc;
  logic [31:0]        x_q;
  logic [31:0]        x2_q;
  logic [31:0]        term_q;
  logic [31:0]        v_q;
  logic [31:0]        est_q;
  logic signed [33:0] sum_q;
  logic [31:0]        fix_rem;
  logic               fix_up;
  logic [31:0]        term_next;
  logic signed [33:0] sum_next;
  logic [31:0]        sum_clamp;
  logic [63:0]        f_raw;
  logic [14:0]        f_calc;

  // Final blend.
  logic [16:0]        pos_delta;
  logic [16:0]        neg_delta;
  logic signed [17:0] delta;
  logic signed [17:0] height_sum;

  // Output registers.
  logic signed [15:0] height_q;
  logic               in_seg_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (pcc_reg_e'(paddr[2]))
      REG_KNOT_COUNT:  prdata = {28'd0, knot_count_q};
      REG_BASE_HEIGHT: prdata = {{16{base_height_q[15]}}, base_height_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q  <= '0;
      base_height_q <= '0;
    end else if (cfg_wr) begin
      unique case (pcc_reg_e'(paddr[2]))
        REG_KNOT_COUNT:  knot_count_q  <= pwdata[3:0];
        REG_BASE_HEIGHT: base_height_q <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // Input acceptance and effective knot count.
  assign in_stall_o   = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign is_eval      = (pcc_kind_e'(kind_i) == KIND_EVAL);
  assign n_eff        = (32'(knot_count_q) > MAX_KNOTS) ? CNT_W'(MAX_KNOTS)
                                                        : CNT_W'(knot_count_q);
  assign enough_knots = (n_eff >= CNT_W'(2));

  // Knot table, x in the upper half and y in the lower half.
  assign ram_we    = in_acc && !is_eval && (32'(knot_index_i) < MAX_KNOTS);
  assign ram_waddr = IDX_W'(knot_index_i);

  pcc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({knot_x_i, knot_y_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[31:16];
  assign rd_y = ram_rdata[15:0];

  // Segment test between the previous knot and the knot just read.
  assign hit     = (q_q >= prev_x_q) && (q_q <= rd_x);
  assign dx_full = {q_q[15], q_q} - {prev_x_q[15], prev_x_q};
  assign w_full  = {rd_x[15], rd_x} - {prev_x_q[15], prev_x_q};
  assign dy_full = {rd_y[15], rd_y} - {prev_y_q[15], prev_y_q};
  assign dy_abs  = dy_full[16] ? 17'(-dy_full) : 17'(dy_full);

  pcc_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dx_i    (dx_full[15:0]),
    .width_i (w_full[15:0]),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  pcc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Decoding of the product register in each state.
  assign x_calc   = 32'((prod + SPAN64) >> (PHASE_BITS + 1));
  assign x2_calc  = 32'((prod + (64'd1 << 29)) >> 30);
  assign v_calc   = 32'(prod >> 30);
  assign est_calc = 32'(prod >> taylor_shift(k_q));

  // The reciprocal estimate is at most one low; one compare fixes it.
  assign fix_rem   = v_q - prod[31:0];
  assign fix_up    = fix_rem >= {23'd0, taylor_div(k_q)};
  assign term_next = est_q + {31'd0, fix_up};
  assign sum_next  = k_q[0] ? (sum_q - $signed({2'b00, term_next}))
                            : (sum_q + $signed({2'b00, term_next}));

  // Sine clamped to [0, 1.0] in Q2.30, then squared into the Q1.14 weight.
  always_comb begin
    if (sum_q < 34'sd0) begin
      sum_clamp = '0;
    end else if (sum_q > 34'sd1073741824) begin
      sum_clamp = 32'd1 << 30;
    end else begin
      sum_clamp = sum_q[31:0];
    end
  end

  assign f_raw  = (prod + (64'd1 << 45)) >> 46;
  assign f_calc = (f_raw > 64'(WEIGHT_ONE)) ? WEIGHT_ONE : f_raw[14:0];

  // Height step: floor of the signed product over 2^14.
  assign pos_delta  = prod[30:14];
  assign neg_delta  = 17'((prod + 64'd16383) >> 14);
  assign delta      = neg_q ? -$signed({1'b0, neg_delta}) : $signed({1'b0, pos_delta});
  assign height_sum = $signed({{2{y0_q[15]}}, y0_q}) + delta;

  // Next state, RAM read address, divider start and multiplier operands.
  always_comb begin
    state_d   = state_q;
    ram_raddr = '0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_eval && enough_knots) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        ram_raddr = IDX_W'(1);
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        ram_raddr = idx_q + IDX_W'(1);
        if (hit) begin
          if (w_full == '0) begin
            state_d = ST_XMUL;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else if (idx_q == last_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_XMUL;
        end
      end
      ST_XMUL: begin
        mul_a   = PI_Q30;
        mul_b   = 32'(t_q);
        state_d = ST_X2MUL;
      end
      ST_X2MUL: begin
        mul_a   = x_calc;
        mul_b   = x_calc;
        state_d = ST_X2GET;
      end
      ST_X2GET: begin
        state_d = ST_TMUL;
      end
      ST_TMUL: begin
        mul_a   = term_q;
        mul_b   = x2_q;
        state_d = ST_TRCP;
      end
      ST_TRCP: begin
        mul_a   = v_calc;
        mul_b   = taylor_recip(k_q);
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        mul_a   = est_calc;
        mul_b   = {23'd0, taylor_div(k_q)};
        state_d = ST_TUPD;
      end
      ST_TUPD: begin
        state_d = (k_q == TAYLOR_TERMS) ? ST_SQR : ST_TMUL;
      end
      ST_SQR: begin
        mul_a   = sum_clamp;
        mul_b   = sum_clamp;
        state_d = ST_SQGET;
      end
      ST_SQGET: begin
        mul_a   = {16'd0, mag_q};
        mul_b   = {17'd0, f_calc};
        state_d = ST_YGET;
      end
      ST_YGET: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      last_q      <= '0;
      k_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_eval) begin
            last_q <= IDX_W'(n_eff - CNT_W'(1));
            if (!enough_knots) begin
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_FIRST: idx_q <= IDX_W'(1);
        ST_SCAN: begin
          if (!hit) begin
            idx_q <= idx_q + IDX_W'(1);
            if (idx_q == last_q) begin
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_X2GET: k_q <= 4'd1;
        ST_TUPD:  k_q <= k_q + 4'd1;
        ST_YGET:  out_valid_q <= 1'b1;
        default:  ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_eval) begin
          q_q      <= query_x_i;
          height_q <= base_height_q;
          in_seg_q <= 1'b0;
        end
      end
      ST_FIRST: begin
        prev_x_q <= rd_x;
        prev_y_q <= rd_y;
      end
      ST_SCAN: begin
        prev_x_q <= rd_x;
        prev_y_q <= rd_y;
        if (hit) begin
          y0_q  <= prev_y_q;
          neg_q <= dy_full[16];
          mag_q <= dy_abs[15:0];
          t_q   <= '0;
        end else begin
          height_q <= base_height_q;
          in_seg_q <= 1'b0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          t_q <= div_quo;
        end
      end
      ST_X2MUL: x_q <= x_calc;
      ST_X2GET: begin
        x2_q   <= x2_calc;
        term_q <= x_q;
        sum_q  <= $signed({2'b00, x_q});
      end
      ST_TRCP: v_q   <= v_calc;
      ST_TCHK: est_q <= est_calc;
      ST_TUPD: begin
        term_q <= term_next;
        sum_q  <= sum_next;
      end
      ST_YGET: begin
        height_q <= height_sum[15:0];
        in_seg_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign height_o     = height_q;
  assign in_segment_o = in_seg_q;

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside the divide wait");

  // While waiting, the divider is running or finishing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divide wait with an idle divider");

  // The reciprocal estimate is never more than one below the true quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TUPD) |-> (fix_rem < {22'd0, taylor_div(k_q), 1'b0}))
    else $error("series term reciprocal out of tolerance");

  // A scan only starts with at least one segment to test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST) |-> (last_q != '0))
    else $error("scan started without a segment");

endmodule

// File: sim/pcc_curve_checker.sv
// Result checker for the cosine curve evaluator: watches both channels and the register port.
`timescale 1ns / 1ps
module pcc_curve_checker
  import pcc_pkg::*;
#(
  parameter int MAX_KNOTS  = 8,
  parameter int PHASE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               kind_i,
  input  logic [2:0]         knot_index_i,
  input  logic signed [15:0] knot_x_i,
  input  logic signed [15:0] knot_y_i,
  input  logic signed [15:0] query_x_i,
  // Result channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] height_i,
  input  logic               in_segment_i,
  // Register port
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  // Status for the testbench top
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint unsigned ANGLE_PI    = 64'd3373259426;  // pi in unsigned Q2.30
  localparam longint unsigned PHASE_SPAN  = 64'd1 << PHASE_BITS;
  localparam longint unsigned WEIGHT_FULL = 64'd16384;

  typedef struct packed {
    logic signed [15:0] height;
    logic               in_segment;
  } curve_point_t;

  logic signed [15:0] knot_x_tbl [MAX_KNOTS];
  logic signed [15:0] knot_y_tbl [MAX_KNOTS];
  logic [3:0]         count_reg;
  logic signed [15:0] base_reg;
  curve_point_t       expected_points [$];
  int                 errors = 0;

  assign fail_count_o = errors;

  // Blend weight 16384 * sin^2(pi * phase / (2 * span)), built from a truncated sine series.
  function automatic int unsigned raised_cos_weight(input int unsigned phase);
    longint unsigned ang, ang2, term, sq;
    longint          acc;
    ang  = (ANGLE_PI * longint'(phase) + PHASE_SPAN) / (2 * PHASE_SPAN);
    ang2 = (ang * ang + (64'd1 << 29)) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    sq = (longint'(acc) * longint'(acc) + (64'd1 << 45)) >> 46;
    if (sq > WEIGHT_FULL) sq = WEIGHT_FULL;
    return int'(sq);
  endfunction

  // Height at a query position: first segment that holds it, or the base height.
  function automatic curve_point_t curve_height(input logic signed [15:0] q);
    curve_point_t pt;
    int           used, ofs, width;
    int unsigned  phase;
    longint       prod;
    pt.height     = base_reg;
    pt.in_segment = 1'b0;
    used = (int'(count_reg) > MAX_KNOTS) ? MAX_KNOTS : int'(count_reg);
    for (int i = 0; i + 1 < used; i++) begin
      if (q >= knot_x_tbl[i] && q <= knot_x_tbl[i + 1]) begin
        ofs   = int'(q) - int'(knot_x_tbl[i]);
        width = int'(knot_x_tbl[i + 1]) - int'(knot_x_tbl[i]);
        // A zero-width segment stays at its left knot.
        phase = (width == 0) ? 0 : (ofs << PHASE_BITS) / width;
        prod  = longint'(int'(knot_y_tbl[i + 1]) - int'(knot_y_tbl[i]))
                * longint'(raised_cos_weight(phase));
        pt.height     = 16'(longint'(knot_y_tbl[i]) + (prod >>> 14));
        pt.in_segment = 1'b1;
        return pt;
      end
    end
    return pt;
  endfunction

  // Track registers and knots, predict on accepted items, compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    curve_point_t want;
    if (!rst_ni) begin
      count_reg = '0;
      base_reg  = '0;
      expected_points.delete();
      pending_o <= 0;
    end else begin
      // Register writes update the copy; reads are compared against it.
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (pcc_reg_e'(paddr_i[2]))
            REG_KNOT_COUNT:  count_reg = pwdata_i[3:0];
            REG_BASE_HEIGHT: base_reg  = pwdata_i[15:0];
            default: ;
          endcase
        end else begin
          case (pcc_reg_e'(paddr_i[2]))
            REG_KNOT_COUNT: begin
              if (prdata_i[3:0] !== count_reg) begin
                errors++;
                $display("%0t: knot_count read expected %0d actual %0d",
                         $time, count_reg, prdata_i[3:0]);
              end
            end
            REG_BASE_HEIGHT: begin
              if (prdata_i[15:0] !== base_reg) begin
                errors++;
                $display("%0t: base_height read expected %0d actual %0d",
                         $time, base_reg, $signed(prdata_i[15:0]));
              end
            end
            default: ;
          endcase
        end
      end

      // Results are compared against the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual height %0d in_segment %0b",
                   $time, height_i, in_segment_i);
        end else begin
          want = expected_points.pop_front();
          if (height_i !== want.height) begin
            errors++;
            $display("%0t: height expected %0d actual %0d", $time, want.height, height_i);
          end
          if (in_segment_i !== want.in_segment) begin
            errors++;
            $display("%0t: in_segment expected %0b actual %0b",
                     $time, want.in_segment, in_segment_i);
          end
        end
      end

      // Accepted items either load a knot or queue a predicted height.
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_EVAL) begin
          expected_points.push_back(curve_height(query_x_i));
        end else if (int'(knot_index_i) < MAX_KNOTS) begin
          knot_x_tbl[knot_index_i] = knot_x_i;
          knot_y_tbl[knot_index_i] = knot_y_i;
        end
      end

      pending_o <= expected_points.size();
    end
  end

endmodule

// File: sim/tb_piecewise_cosine_curve_eval.sv
// Testbench top for the cosine curve evaluator: drives items and registers, gives the verdict.
`timescale 1ns / 1ps
module tb_piecewise_cosine_curve_eval;
  import pcc_pkg::*;

  localparam int MAX_KNOTS     = 8;
  localparam int PHASE_BITS    = 10;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 165;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int FLOOD_ITEMS   = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic [2:0]         knot_index_i;
  logic signed [15:0] knot_x_i;
  logic signed [15:0] knot_y_i;
  logic signed [15:0] query_x_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] height_o;
  logic               in_segment_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;

  // Idling odds in percent: per item on the sending side, per cycle on the receiving side.
  int gap_odds   = 0;
  int stall_odds = 0;
  int gap_menu   [4] = '{0, 5, 20, 50};
  int stall_menu [4] = '{0, 3, 10, 30};

  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  // Knot positions as loaded, used only to aim queries into segments.
  int knot_pos [MAX_KNOTS];
  int cur_count = 0;

  piecewise_cosine_curve_eval #(
    .MAX_KNOTS (MAX_KNOTS),
    .PHASE_BITS(PHASE_BITS)
  ) DUT (.*);

  pcc_curve_checker #(
    .MAX_KNOTS (MAX_KNOTS),
    .PHASE_BITS(PHASE_BITS)
  ) u_curve_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .kind_i      (kind_i),
    .knot_index_i(knot_index_i),
    .knot_x_i    (knot_x_i),
    .knot_y_i    (knot_y_i),
    .query_x_i   (query_x_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .height_i    (height_o),
    .in_segment_i(in_segment_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock, 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Hard limit on the run.
  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiving side: random stall bursts, plus one long hold-off on request.
  initial begin : sink
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (stall_odds != 0 && $urandom_range(99, 0) < stall_odds) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(11, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait until it is taken.
  task automatic send_item(input pcc_kind_e kind, input logic [2:0] slot,
                           input logic signed [15:0] kx, input logic signed [15:0] ky,
                           input logic signed [15:0] qx);
    if (gap_odds != 0 && $urandom_range(99, 0) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    knot_index_i <= slot;
    knot_x_i     <= kx;
    knot_y_i     <= ky;
    query_x_i    <= qx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_write(input logic [2:0] slot, input logic signed [15:0] x,
                            input logic signed [15:0] y);
    knot_pos[slot] = int'(x);
    send_item(KIND_WRITE, slot, x, y, 16'($urandom));
  endtask

  task automatic send_eval(input logic signed [15:0] q);
    send_item(KIND_EVAL, 3'($urandom), 16'($urandom), 16'($urandom), q);
  endtask

  // One register access: setup cycle, then access until pready.
  task automatic cfg_access(input pcc_reg_e sel, input logic wr, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then give the block time to go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written once the block is idle; unused data bits carry noise.
  task automatic reconfigure(input int count, input int base);
    settle();
    cfg_access(REG_KNOT_COUNT, 1'b1, {28'($urandom), 4'(count)});
    cfg_access(REG_BASE_HEIGHT, 1'b1, {16'($urandom), 16'(base)});
    cfg_access(REG_KNOT_COUNT, 1'b0, '0);
    cfg_access(REG_BASE_HEIGHT, 1'b0, '0);
    cur_count = count;
  endtask

  // Load all slots with ascending positions; small steps give many narrow or empty segments.
  task automatic load_table(input int max_step);
    int pos;
    pos = -32768 + int'($urandom_range(65535 - (MAX_KNOTS - 1) * max_step, 0));
    for (int k = 0; k < MAX_KNOTS; k++) begin
      send_write(3'(k), 16'(pos), 16'($urandom));
      pos += int'($urandom_range(max_step, 0));
    end
  endtask

  function automatic int pick_step();
    case ($urandom_range(2, 0))
      0:       return 3;
      1:       return 300;
      default: return 9000;
    endcase
  endfunction

  // Mostly queries inside a segment, some exactly on a knot, the rest anywhere.
  function automatic logic signed [15:0] pick_query();
    int used, seg, lo, hi, roll;
    used = (cur_count > MAX_KNOTS) ? MAX_KNOTS : cur_count;
    roll = $urandom_range(99, 0);
    if (used >= 2 && roll < 60) begin
      seg = $urandom_range(used - 2, 0);
      lo  = knot_pos[seg];
      hi  = knot_pos[seg + 1];
      if (lo <= hi) return 16'(lo + int'($urandom_range(hi - lo, 0)));
    end else if (used >= 1 && roll < 75) begin
      return 16'(knot_pos[$urandom_range(used - 1, 0)]);
    end
    return 16'($urandom);
  endfunction

  task automatic random_item();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      load_table(pick_step());
    end else if (roll < 13) begin
      // Stray knot writes may break the ordering of the table.
      send_write(3'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_eval(pick_query());
    end
  endtask

  initial begin : stimulus
    int count, roll, saved;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_WRITE;
    knot_index_i = '0;
    knot_x_i     = '0;
    knot_y_i     = '0;
    query_x_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_odds   = 10;
    stall_odds = 10;

    // No knots after reset: the base height comes back.
    send_eval(16'sd0);
    reconfigure(1, -32768);
    send_eval(16'sd32767);

    // Table with a zero-width first segment, a reversed segment and extreme values.
    send_write(3'd0, -16'sd32768, 16'sd32767);
    send_write(3'd1, -16'sd32768, -16'sd32768);
    send_write(3'd2, -16'sd16384, 16'sd100);
    send_write(3'd3, 16'sd0, -16'sd32768);
    send_write(3'd4, -16'sd100, 16'sd5);
    send_write(3'd5, 16'sd4096, 16'sd32767);
    send_write(3'd6, 16'sd32767, -16'sd32768);
    send_write(3'd7, 16'sd32767, -16'sd1);
    // A single knot still gives no segment.
    send_eval(-16'sd32768);

    reconfigure(8, 32767);
    send_eval(-16'sd32768);
    send_eval(-16'sd24576);
    send_eval(-16'sd16384);
    send_eval(-16'sd50);
    send_eval(16'sd2000);
    send_eval(16'sd20000);
    send_eval(16'sd32767);

    // A count above the table size acts as a full table.
    reconfigure(15, -1);
    send_eval(16'sd32767);
    send_eval(-16'sd7);

    // Two knots: only the first segment exists.
    reconfigure(2, 12345);
    send_eval(16'sd0);
    send_eval(-16'sd32768);

    // Random phases, each with its own register setting and idling mix.
    for (int ph = 0; ph < PHASES; ph++) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) begin
        count = $urandom_range(8, 2);
      end else if (roll < 85) begin
        count = $urandom_range(15, 9);
      end else begin
        count = $urandom_range(1, 0);
      end
      reconfigure(count, int'($urandom_range(65535, 0)) - 32768);
      if (ph == PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = gap_menu[$urandom_range(3, 0)];
        stall_odds = stall_menu[$urandom_range(3, 0)];
      end
      load_table(pick_step());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 50) begin
          // Keep offering back to back while the receiver holds off, so the block backs up.
          saved    = gap_odds;
          gap_odds = 0;
          hold_go  = 1'b1;
          repeat (FLOOD_ITEMS) send_eval(pick_query());
          gap_odds = saved;
        end
        random_item();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
